// File: rtl/lpm_pkg.sv
// Shared constants, types and tables for the log-polar coordinate map generator.
package lpm_pkg;

   localparam int COORD_BITS    = 12;
   localparam int CORDIC_STAGES = 16;
   localparam int PIX_BITS      = 12;
   localparam int CTR_BITS      = 16;
   localparam int CU            = (COORD_BITS < PIX_BITS) ? COORD_BITS : PIX_BITS;
   localparam int DW            = ((CU + 4 > CTR_BITS) ? CU + 4 : CTR_BITS) + 1;
   localparam int SQW           = 2 * DW;
   localparam int VW            = SQW + 8;
   localparam int RW            = VW / 2;
   localparam int RMW           = RW + 2;
   localparam int FB            = 24;
   localparam int UW            = RW + FB + 1;
   localparam int NSH           = $clog2(UW);
   localparam int MW            = 31;
   localparam int LIW           = $clog2(RW + 1);
   localparam int LW            = LIW + FB;
   localparam int LNPW          = LW + 25;
   localparam int CPW           = LW + 25;
   localparam int COL_SH        = FB + 12 - 8;
   localparam int CW            = CPW - COL_SH;
   localparam int XW            = DW + FB + 2;
   localparam int ZW            = 28;
   localparam int THW           = 19;
   localparam int RRW           = ZW - 8;
   localparam int OFW           = 20;
   localparam int PHW           = 22;
   localparam int GW            = 24;
   localparam int PRW           = PHW + GW + 1;
   localparam int ROW_SH        = 20;
   localparam int RQW           = PRW - ROW_SH;
   localparam int COL_W         = 20;
   localparam int ROW_W         = 21;

   localparam logic signed [ZW-1:0]  PI_Q24      = ZW'(52707179);
   localparam logic signed [ZW-1:0]  TWO_PI_Q24  = ZW'(105414357);
   localparam logic [THW-1:0]        PI_Q16      = THW'(205887);
   localparam logic [RRW-1:0]        TWO_PI_RR   = RRW'(411775);
   localparam logic [THW-1:0]        TWO_PI_Q16  = THW'(411775);
   localparam logic signed [PHW-1:0] TWO_PI_PHI  = PHW'(411775);
   localparam logic [FB-1:0]         LN2_Q24     = FB'(11629080);
   localparam logic [CW-1:0]         COL_MAX     = CW'(1048575);
   localparam logic signed [RQW-1:0] ROW_MAX     = RQW'(1048575);
   localparam logic signed [RQW-1:0] ROW_MIN     = -RQW'(1048576);

   localparam int ST_SQ   = 1;
   localparam int ST_ROOT = ST_SQ + RW;
   localparam int ST_CORD = ST_SQ + CORDIC_STAGES;
   localparam int ST_ANG  = ST_CORD + 1;
   localparam int ST_PHI  = ST_ANG + 1;
   localparam int ST_RPR  = ST_PHI + 1;
   localparam int ST_RSAT = ST_RPR + 1;
   localparam int ST_U    = ST_ROOT + 1;
   localparam int ST_N1   = ST_U + 1;
   localparam int ST_N2   = ST_N1 + 1;
   localparam int ST_LOG  = ST_N2 + FB;
   localparam int ST_LN   = ST_LOG + 1;
   localparam int ST_COL  = ST_LN + 1;
   localparam int ST_OUT  = ST_COL + 1;
   localparam int DEPTH   = ST_OUT + 1;
   localparam int ROW_DLY = ST_OUT - ST_RSAT;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_SCALE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RHO_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PHI_GAIN     = 3'd5;

   typedef struct packed {
      logic [VW-1:0]  v;
      logic [RMW-1:0] rem;
      logic [RW-1:0]  root;
   } sqrt_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 spec;
      logic                 neg;
   } cordic_type;

   typedef struct packed {
      logic [MW-1:0]  m;
      logic [FB-1:0]  f;
      logic [LIW-1:0] li;
   } log_type;

   function automatic logic signed [ZW-1:0] atan_q24(input logic [4:0] idx);
      logic signed [ZW-1:0] a;
      case (idx)
         5'd0:  a = ZW'(13176795);
         5'd1:  a = ZW'(7778716);
         5'd2:  a = ZW'(4110060);
         5'd3:  a = ZW'(2086331);
         5'd4:  a = ZW'(1047214);
         5'd5:  a = ZW'(524117);
         5'd6:  a = ZW'(262123);
         5'd7:  a = ZW'(131069);
         5'd8:  a = ZW'(65536);
         5'd9:  a = ZW'(32768);
         5'd10: a = ZW'(16384);
         5'd11: a = ZW'(8192);
         5'd12: a = ZW'(4096);
         5'd13: a = ZW'(2048);
         5'd14: a = ZW'(1024);
         5'd15: a = ZW'(512);
         5'd16: a = ZW'(256);
         5'd17: a = ZW'(128);
         5'd18: a = ZW'(64);
         5'd19: a = ZW'(32);
         5'd20: a = ZW'(16);
         5'd21: a = ZW'(8);
         5'd22: a = ZW'(4);
         5'd23: a = ZW'(2);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// File: rtl/lpm_req_if.sv
// Request channel carrying one destination pixel coordinate per transfer.
interface lpm_req_if;
   logic                         valid;
   logic                         ready;
   logic [lpm_pkg::PIX_BITS-1:0] pixel_x;
   logic [lpm_pkg::PIX_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

// File: rtl/lpm_rsp_if.sv
// Response channel carrying one source coordinate pair per transfer.
interface lpm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [lpm_pkg::COL_W-1:0]        map_col;
   logic signed [lpm_pkg::ROW_W-1:0] map_row;

   modport source (output valid, output map_col, output map_row, input ready);
   modport sink (input valid, input map_col, input map_row, output ready);
endinterface

// File: rtl/lpm_csr_if.sv
// Register write channel carrying a register index and write data.
interface lpm_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lpm_pkg::CSR_IDX_W-1:0]  index;
   logic [lpm_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/lpm_sqrt_cell.sv
// One restoring square root cell that resolves one root bit per cycle while enabled.
module lpm_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  lpm_pkg::sqrt_type stage_i,
   output lpm_pkg::sqrt_type stage_o
);
   import lpm_pkg::*;

   sqrt_type       stage_ff;
   sqrt_type       stage_in;
   logic [RMW-1:0] rem_sh;
   logic [RMW-1:0] trial;

   always_comb begin
      rem_sh     = {stage_i.rem[RMW-3:0], stage_i.v[VW-1:VW-2]};
      trial      = {stage_i.root, 2'b01};
      stage_in.v = {stage_i.v[VW-3:0], 2'b00};
      if (rem_sh >= trial) begin
         stage_in.rem  = rem_sh - trial;
         stage_in.root = {stage_i.root[RW-2:0], 1'b1};
      end else begin
         stage_in.rem  = rem_sh;
         stage_in.root = {stage_i.root[RW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;
endmodule

// File: rtl/lpm_cordic_cell.sv
// One vectoring rotation cell of the angle chain.
module lpm_cordic_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          idx,
   input  lpm_pkg::cordic_type stage_i,
   output lpm_pkg::cordic_type stage_o
);
   import lpm_pkg::*;

   cordic_type           stage_ff;
   cordic_type           stage_in;
   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;
   logic signed [ZW-1:0] at;

   always_comb begin
      xs            = stage_i.x >>> idx;
      ys            = stage_i.y >>> idx;
      at            = atan_q24(idx);
      stage_in.spec = stage_i.spec;
      stage_in.neg  = stage_i.neg;
      if (stage_i.y > 0) begin
         stage_in.x = stage_i.x + ys;
         stage_in.y = stage_i.y - xs;
         stage_in.z = stage_i.z + at;
      end else begin
         stage_in.x = stage_i.x - ys;
         stage_in.y = stage_i.y + xs;
         stage_in.z = stage_i.z - at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;
endmodule

// File: rtl/lpm_log_cell.sv
// One squaring cell that resolves one fraction bit of the base-two logarithm.
module lpm_log_cell (
   input  logic             clock,
   input  logic             en,
   input  lpm_pkg::log_type stage_i,
   output lpm_pkg::log_type stage_o
);
   import lpm_pkg::*;

   log_type         stage_ff;
   log_type         stage_in;
   logic [2*MW-1:0] prod;
   logic [MW:0]     t;

   always_comb begin
      prod        = stage_i.m * stage_i.m;
      t           = prod[2*MW-1:MW-1];
      stage_in.li = stage_i.li;
      if (t[MW]) begin
         stage_in.m = t[MW:1];
         stage_in.f = {stage_i.f[FB-2:0], 1'b1};
      end else begin
         stage_in.m = t[MW-1:0];
         stage_in.f = {stage_i.f[FB-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_o = stage_ff;
endmodule

// File: rtl/log_polar_map_generator.sv
// Top level of the log-polar coordinate map generator pipeline.
// The block maps each destination pixel to a log-polar source coordinate.
// Requests arrive on req_if as one pixel column and row per transfer, and
// each request yields exactly one response on rsp_if holding the saturated
// source column and row in Q12.8. Registers are written through csr_if,
// which is always ready; writes are expected only while the pipeline is empty.
// The pipeline accepts one request every cycle when the receiver does not
// stall. Its depth is set by the square root cell chain, one root bit per
// cell, followed by the logarithm cell chain, one fraction bit per cell. The
// angle chain runs alongside and its result waits in a delay line.
// When the receiver holds ready low while a response is shown, the whole
// pipeline freezes and req_if.ready drops in the same cycle; nothing is lost.
// Reset clears all in-flight items and loads the register reset values.
module log_polar_map_generator (
   input  logic      clock,
   input  logic      reset,
   lpm_req_if.sink   req_if,
   lpm_rsp_if.source rsp_if,
   lpm_csr_if.sink   csr_if
);
   import lpm_pkg::*;

   logic [CTR_BITS-1:0]   center_x_ff;
   logic [CTR_BITS-1:0]   center_y_ff;
   logic [GW-1:0]         inv_scale_ff;
   logic [GW-1:0]         rho_gain_ff;
   logic signed [OFW-1:0] angle_offset_ff;
   logic [GW-1:0]         phi_gain_ff;

   logic                  pipe_en;
   logic [DEPTH-1:0]      vld_ff;
   logic [DEPTH-1:0]      vld_in;

   logic [DW-2:0]         px_w;
   logic [DW-2:0]         py_w;
   logic [DW-2:0]         cx_w;
   logic [DW-2:0]         cy_w;
   logic signed [DW-1:0]  dx_ff;
   logic signed [DW-1:0]  dy_ff;
   logic signed [DW-1:0]  dx_in;
   logic signed [DW-1:0]  dy_in;

   logic signed [SQW-1:0] sx;
   logic signed [SQW-1:0] sy;
   logic [SQW-1:0]        sq;
   logic signed [XW-1:0]  xe;
   logic signed [XW-1:0]  ye;
   sqrt_type              sq0_in;
   cordic_type            cd0_in;
   sqrt_type              sq_st [RW+1];
   cordic_type            cd_st [CORDIC_STAGES+1];
   log_type               lg_st [FB+1];

   logic signed [ZW-1:0]  z2;
   logic [ZW-1:0]         zr;
   logic [RRW-1:0]        rr;
   logic [THW-1:0]        theta_ff;
   logic [THW-1:0]        theta_in;
   logic signed [PHW-1:0] phi_ff;
   logic signed [PHW-1:0] phi_in;
   logic signed [PRW-1:0] rp;
   logic signed [RQW-1:0] rq_ff;
   logic signed [RQW-1:0] rq_in;
   logic signed [ROW_W-1:0] rsat_ff;
   logic signed [ROW_W-1:0] rsat_in;
   logic signed [ROW_W-1:0] rowd_ff [ROW_DLY];

   logic [UW-1:0]         u_ff;
   logic [UW-1:0]         u_in;
   logic [UW-1:0]         n1_ff;
   logic [UW-1:0]         n1_in;
   logic [NSH-1:0]        s1_ff;
   logic [NSH-1:0]        s1_in;
   logic [UW-1:0]         n2;
   logic [NSH-1:0]        s2;
   log_type               lg0_in;
   logic [LW-1:0]         lv;
   logic [LNPW-1:0]       lnp;
   logic [LW-1:0]         ln_ff;
   logic [LW-1:0]         ln_in;
   logic [CPW-1:0]        cp;
   logic [CW-1:0]         col_ff;
   logic [CW-1:0]         col_in;
   logic [COL_W-1:0]      out_col_ff;
   logic [COL_W-1:0]      out_col_in;

   // Register file.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         inv_scale_ff    <= GW'(65536);
         rho_gain_ff     <= GW'(4096);
         angle_offset_ff <= '0;
         phi_gain_ff     <= GW'(4096);
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_CENTER_X:     center_x_ff     <= csr_if.data[CTR_BITS-1:0];
            CSR_CENTER_Y:     center_y_ff     <= csr_if.data[CTR_BITS-1:0];
            CSR_INV_SCALE:    inv_scale_ff    <= csr_if.data[GW-1:0];
            CSR_RHO_GAIN:     rho_gain_ff     <= csr_if.data[GW-1:0];
            CSR_ANGLE_OFFSET: angle_offset_ff <= $signed(csr_if.data[OFW-1:0]);
            CSR_PHI_GAIN:     phi_gain_ff     <= csr_if.data[GW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: the whole chain advances unless a response is stalled.
   assign pipe_en      = !vld_ff[ST_OUT] || rsp_if.ready;
   assign req_if.ready = pipe_en;
   assign vld_in       = {vld_ff[DEPTH-2:0], req_if.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= vld_in;
      end
   end

   // Offsets from the polar center.
   always_comb begin
      px_w  = (DW-1)'({req_if.pixel_x[CU-1:0], 4'b0000});
      py_w  = (DW-1)'({req_if.pixel_y[CU-1:0], 4'b0000});
      cx_w  = (DW-1)'(center_x_ff);
      cy_w  = (DW-1)'(center_y_ff);
      dx_in = $signed({1'b0, px_w}) - $signed({1'b0, cx_w});
      dy_in = $signed({1'b0, py_w}) - $signed({1'b0, cy_w});
   end

   // Squared radius and the start vector of the angle chain.
   always_comb begin
      sx          = dx_ff * dx_ff;
      sy          = dy_ff * dy_ff;
      sq          = $unsigned(sx) + $unsigned(sy);
      sq0_in.v    = {sq, 8'h00};
      sq0_in.rem  = '0;
      sq0_in.root = '0;
      xe          = {{(XW-DW-FB){dx_ff[DW-1]}}, dx_ff, {FB{1'b0}}};
      ye          = {{(XW-DW-FB){dy_ff[DW-1]}}, dy_ff, {FB{1'b0}}};
      cd0_in.spec = (dy_ff == '0);
      cd0_in.neg  = dx_ff[DW-1];
      if (dx_ff[DW-1]) begin
         cd0_in.x = -xe;
         cd0_in.y = -ye;
         cd0_in.z = PI_Q24;
      end else begin
         cd0_in.x = xe;
         cd0_in.y = ye;
         cd0_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
         sq_st[0] <= sq0_in;
         cd_st[0] <= cd0_in;
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_sqrt
      lpm_sqrt_cell u_cell (
         .clock   (clock),
         .en      (pipe_en),
         .stage_i (sq_st[k]),
         .stage_o (sq_st[k+1])
      );
   end

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
      lpm_cordic_cell u_cell (
         .clock   (clock),
         .en      (pipe_en),
         .idx     (5'(k)),
         .stage_i (cd_st[k]),
         .stage_o (cd_st[k+1])
      );
   end

   // Angle result, offset with a single wrap, and row scaling.
   always_comb begin
      z2 = cd_st[CORDIC_STAGES].z;
      if (z2 < 0) begin
         z2 = z2 + TWO_PI_Q24;
      end
      if (z2 < 0) begin
         z2 = '0;
      end
      zr = $unsigned(z2) + ZW'(128);
      rr = zr[ZW-1:8];
      if (rr >= TWO_PI_RR) begin
         rr = rr - TWO_PI_RR;
      end
      if (cd_st[CORDIC_STAGES].spec) begin
         theta_in = cd_st[CORDIC_STAGES].neg ? PI_Q16 : '0;
      end else begin
         theta_in = rr[THW-1:0];
      end
   end

   always_comb begin
      phi_in = PHW'($signed({1'b0, theta_ff})) + PHW'(angle_offset_ff);
      if (phi_in < 0) begin
         phi_in = phi_in + TWO_PI_PHI;
      end else if (phi_in > TWO_PI_PHI) begin
         phi_in = phi_in - TWO_PI_PHI;
      end
   end

   always_comb begin
      rp    = PRW'(phi_ff) * PRW'($signed({1'b0, phi_gain_ff})) + (PRW'(1) <<< (ROW_SH - 1));
      rq_in = RQW'(rp >>> ROW_SH);
      if (rq_ff > ROW_MAX) begin
         rsat_in = ROW_W'(ROW_MAX);
      end else if (rq_ff < ROW_MIN) begin
         rsat_in = ROW_W'(ROW_MIN);
      end else begin
         rsat_in = ROW_W'(rq_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         theta_ff   <= theta_in;
         phi_ff     <= phi_in;
         rq_ff      <= rq_in;
         rsat_ff    <= rsat_in;
         rowd_ff[0] <= rsat_ff;
         for (int i = 1; i < ROW_DLY; i++) begin
            rowd_ff[i] <= rowd_ff[i-1];
         end
      end
   end

   // Scaled radius plus one, then leading one search in two steps.
   always_comb begin
      u_in  = UW'(sq_st[RW].root) * UW'(inv_scale_ff) + (UW'(1) << FB);
      n1_in = u_ff;
      s1_in = '0;
      for (int k = NSH - 1; k >= NSH / 2; k--) begin
         if ((n1_in >> (UW - (1 << k))) == '0) begin
            n1_in = n1_in << (1 << k);
            s1_in = s1_in + NSH'(1 << k);
         end
      end
      n2 = n1_ff;
      s2 = s1_ff;
      for (int k = NSH / 2 - 1; k >= 0; k--) begin
         if ((n2 >> (UW - (1 << k))) == '0) begin
            n2 = n2 << (1 << k);
            s2 = s2 + NSH'(1 << k);
         end
      end
      lg0_in.m  = n2[UW-1 -: MW];
      lg0_in.f  = '0;
      lg0_in.li = LIW'(RW - int'(s2));
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         u_ff     <= u_in;
         n1_ff    <= n1_in;
         s1_ff    <= s1_in;
         lg_st[0] <= lg0_in;
      end
   end

   for (genvar k = 0; k < FB; k++) begin : g_log
      lpm_log_cell u_cell (
         .clock   (clock),
         .en      (pipe_en),
         .stage_i (lg_st[k]),
         .stage_o (lg_st[k+1])
      );
   end

   // Natural log, column scaling and output saturation.
   always_comb begin
      lv     = {lg_st[FB].li, lg_st[FB].f};
      lnp    = LNPW'(lv) * LNPW'(LN2_Q24) + (LNPW'(1) << (FB - 1));
      ln_in  = LW'(lnp >> FB);
      cp     = CPW'(ln_ff) * CPW'(rho_gain_ff) + (CPW'(1) << (COL_SH - 1));
      col_in = CW'(cp >> COL_SH);
      if (col_ff > COL_MAX) begin
         out_col_in = COL_W'(COL_MAX);
      end else begin
         out_col_in = col_ff[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ln_ff      <= ln_in;
         col_ff     <= col_in;
         out_col_ff <= out_col_in;
      end
   end

   assign rsp_if.valid   = vld_ff[ST_OUT];
   assign rsp_if.map_col = out_col_ff;
   assign rsp_if.map_row = rowd_ff[ROW_DLY-1];

`ifndef SYNTHESIS
   ast_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ready |-> !req_if.ready)
      else $error("Input accepted while a response is stalled.");

   ast_theta_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_ANG] |-> theta_ff < TWO_PI_Q16)
      else $error("Angle left the range below two pi.");

   ast_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("Response valid right after reset.");
`endif
endmodule
